// ----- hw/rtl/fdi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdi_pkg;

	// Widths of the configuration registers and of the port
	localparam int FW_W       = 10;
	localparam int FH_W       = 9;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THREE_MODE   = 2'd2
	} fdi_reg_t;

	// Register values after reset
	localparam int FW_RESET   = 640;
	localparam int FH_RESET   = 480;
	localparam logic MODE_RESET = 1'b1;

	// Pixel and result widths
	localparam int PIX_W       = 8;
	localparam int INT_W       = 27;
	localparam int ROWSUM_W    = 18;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	// Fixed-point gray conversion: (4899 R + 9617 G + 1868 B + 8192) >> 14.
	// The largest sum is below 2^22, so the result never exceeds 255.
	localparam int GRAY_ACC_W  = 22;
	localparam int GRAY_SHIFT  = 14;
	localparam logic [GRAY_ACC_W-1:0] GRAY_R_WT = 22'd4899;
	localparam logic [GRAY_ACC_W-1:0] GRAY_G_WT = 22'd9617;
	localparam logic [GRAY_ACC_W-1:0] GRAY_B_WT = 22'd1868;
	localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = 22'd8192;

	// Classified pixel as it travels from the front to the back
	typedef struct packed {
		logic [PIX_W-1:0] gray;
		logic             three_mode;
		logic             row_zero;
		logic             line_end;
		logic             frame_end;
	} fdi_tag_t;

	// One result item
	typedef struct packed {
		logic             frame_end;
		logic [INT_W-1:0] integral_sum;
		logic [PIX_W-1:0] motion;
	} fdi_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fdi_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Small register FIFO. DEPTH must be a power of two.
module fdi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level; pointers wrap naturally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fdi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Front end: holds the configuration, tracks the raster position, weights the
// color components and hands classified pixels to the queue.
module fdi_front #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [fdi_pkg::IN_TDATA_W-1:0]      in_data,
	input  wire logic                                cfg_we,
	input  wire logic [fdi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [fdi_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                clear_busy,
	input  wire logic                                q_full,
	output logic                                     q_push,
	output fdi_pkg::fdi_tag_t                        q_tag,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  q_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]             q_col
);

	import fdi_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EWW = ((FW_W > CW) ? FW_W : CW) + 1;
	localparam int EHW = ((FH_W > RW) ? FH_W : RW) + 1;
	localparam int W_RST = (FW_RESET > MAX_WIDTH) ? MAX_WIDTH : FW_RESET;
	localparam int H_RST = (FH_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FH_RESET;

	// Configuration, stored as clamped size minus one
	logic [CW-1:0] wm1_q;
	logic [RW-1:0] hm1_q;
	logic          mode_q;

	// Raster position and start address of the current line
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] base_q;

	// Product stage
	logic                  v_f1;
	logic [GRAY_ACC_W-1:0] pr_f1;
	logic [GRAY_ACC_W-1:0] pg_f1;
	logic [GRAY_ACC_W-1:0] pb_f1;
	logic                  mode_f1;
	logic                  row_zero_f1;
	logic                  line_end_f1;
	logic                  frame_end_f1;
	logic [AW-1:0]         addr_f1;
	logic [CW-1:0]         col_f1;

	logic [FW_W-1:0]       w_wr;
	logic [FH_W-1:0]       h_wr;
	logic [EWW-1:0]        w_ext;
	logic [EHW-1:0]        h_ext;
	logic [CW-1:0]         w_new;
	logic [RW-1:0]         h_new;
	logic                  accept;
	logic                  line_end;
	logic                  last_row;
	logic [GRAY_ACC_W-1:0] gray_sum;

	// Clamp written sizes to 1..MAX and keep them minus one.
	assign w_wr  = cfg_data[FW_W-1:0];
	assign h_wr  = cfg_data[FH_W-1:0];
	assign w_ext = EWW'(w_wr);
	assign h_ext = EHW'(h_wr);

	always_comb begin
		if (w_wr == '0) begin
			w_new = '0;
		end else if (w_ext > EWW'(MAX_WIDTH)) begin
			w_new = CW'(MAX_WIDTH - 1);
		end else begin
			w_new = CW'(w_ext - EWW'(1));
		end
		if (h_wr == '0) begin
			h_new = '0;
		end else if (h_ext > EHW'(MAX_HEIGHT)) begin
			h_new = RW'(MAX_HEIGHT - 1);
		end else begin
			h_new = RW'(h_ext - EHW'(1));
		end
	end

	// Accept while no clearing sweep runs and the product stage is free or drains this cycle.
	assign in_ready = !clear_busy && (!v_f1 || !q_full);
	assign accept   = in_valid && in_ready;
	assign line_end = (col_q >= wm1_q);
	assign last_row = (row_q >= hm1_q);

	// Configuration, position and stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q  <= CW'(W_RST - 1);
			hm1_q  <= RW'(H_RST - 1);
			mode_q <= MODE_RESET;
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
			v_f1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						wm1_q <= w_new;
					end
					REG_FRAME_HEIGHT: begin
						hm1_q <= h_new;
					end
					REG_THREE_MODE: begin
						mode_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (line_end) begin
					col_q <= '0;
					if (last_row) begin
						row_q  <= '0;
						base_q <= '0;
					end else begin
						row_q  <= row_q + RW'(1);
						base_q <= base_q + AW'(MAX_WIDTH);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (accept) begin
				v_f1 <= 1'b1;
			end else if (q_push) begin
				v_f1 <= 1'b0;
			end
		end
	end

	// Weighted components and pixel classification.
	always_ff @(posedge clk) begin
		if (accept) begin
			pb_f1        <= GRAY_B_WT * GRAY_ACC_W'(in_data[7:0]);
			pg_f1        <= GRAY_G_WT * GRAY_ACC_W'(in_data[15:8]);
			pr_f1        <= GRAY_R_WT * GRAY_ACC_W'(in_data[23:16]);
			mode_f1      <= mode_q;
			row_zero_f1  <= (row_q == '0);
			line_end_f1  <= line_end;
			frame_end_f1 <= line_end && last_row;
			addr_f1      <= base_q + AW'(col_q);
			col_f1       <= col_q;
		end
	end

	// Sum and round to gray on the way into the queue.
	assign gray_sum = pr_f1 + pg_f1 + pb_f1 + GRAY_ROUND;
	assign q_push   = v_f1 && !q_full;

	always_comb begin
		q_tag.gray       = gray_sum[GRAY_SHIFT +: PIX_W];
		q_tag.three_mode = mode_f1;
		q_tag.row_zero   = row_zero_f1;
		q_tag.line_end   = line_end_f1;
		q_tag.frame_end  = frame_end_f1;
	end

	assign q_addr = addr_f1;
	assign q_col  = col_f1;

endmodule

`default_nettype wire

// ----- hw/rtl/fdi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Back end: frame stores, frame difference and the integral image.
// Stage 1 sees the frame store word, stage 2 the integral row above.
module fdi_back #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480,
	parameter int OUT_DEPTH  = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     q_valid,
	input  wire fdi_pkg::fdi_tag_t                        q_tag,
	input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  q_addr,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]             q_col,
	output logic                                          q_pop,
	input  wire logic                                     out_taken,
	output logic                                          res_valid,
	output fdi_pkg::fdi_result_t                          res,
	output logic                                          clear_busy
);

	import fdi_pkg::*;

	localparam int FD = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(FD);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int OW = $clog2(OUT_DEPTH + 1);
	localparam int WW = 2 * PIX_W;

	// Frame store word: previous gray in the upper byte, older gray below.
	logic [WW-1:0]    fr_mem [FD];
	logic [INT_W-1:0] rr_mem [MAX_WIDTH];

	// Clearing sweep after reset
	logic          clearing_q;
	logic [AW-1:0] clr_q;

	// Items popped and not yet taken at the output
	logic [OW-1:0] outst_q;

	logic [ROWSUM_W-1:0] rowsum_q;

	// Stage 1
	logic          v_s1;
	fdi_tag_t      tag_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] col_s1;
	logic [WW-1:0] fr_rd_s1;
	logic          fr_fwd_s1;
	logic [WW-1:0] fr_fwd_word_s1;

	// Stage 2
	logic             v_s2;
	logic [PIX_W-1:0] motion_s2;
	logic             row_zero_s2;
	logic             line_end_s2;
	logic             frame_end_s2;
	logic [CW-1:0]    col_s2;
	logic [INT_W-1:0] rr_rd_s2;
	logic             rr_fwd_s2;
	logic [INT_W-1:0] rr_fwd_sum_s2;

	logic [WW-1:0]       fr_word;
	logic [PIX_W-1:0]    g_old;
	logic [PIX_W-1:0]    g_prev;
	logic [PIX_W-1:0]    d_old;
	logic [PIX_W-1:0]    d_new;
	logic [PIX_W-1:0]    motion;
	logic [WW-1:0]       wr_word;
	logic                fr_we;
	logic [AW-1:0]       fr_wa;
	logic [WW-1:0]       fr_wd;
	logic [INT_W-1:0]    above;
	logic [ROWSUM_W-1:0] rs_next;
	logic [INT_W-1:0]    sum;
	logic                rr_we;
	logic [CW-1:0]       rr_wa;
	logic [INT_W-1:0]    rr_wd;

	assign clear_busy = clearing_q;

	// Pop only when the output buffer is sure to have room for the result.
	assign q_pop = q_valid && !clearing_q && (outst_q < OW'(OUT_DEPTH));

	// Stage 1: frame store word, bypassed from the write of the item just ahead.
	assign fr_word = fr_fwd_s1 ? fr_fwd_word_s1 : fr_rd_s1;
	assign g_old   = fr_word[PIX_W-1:0];
	assign g_prev  = fr_word[WW-1:PIX_W];
	assign d_old   = (g_old > g_prev) ? (g_old - g_prev) : (g_prev - g_old);
	assign d_new   = (g_prev > tag_s1.gray) ? (g_prev - tag_s1.gray) : (tag_s1.gray - g_prev);
	assign wr_word = {tag_s1.gray, g_prev};

	always_comb begin
		if (tag_s1.three_mode) begin
			motion = (d_old < d_new) ? d_old : d_new;
		end else begin
			motion = d_new;
		end
	end

	assign fr_we = clearing_q || v_s1;
	assign fr_wa = clearing_q ? clr_q : addr_s1;
	assign fr_wd = clearing_q ? '0 : wr_word;

	// Stage 2: row sum and integral, row above bypassed like the frame store.
	assign above   = row_zero_s2 ? '0 : (rr_fwd_s2 ? rr_fwd_sum_s2 : rr_rd_s2);
	assign rs_next = rowsum_q + ROWSUM_W'(motion_s2);
	assign sum     = above + INT_W'(rs_next);

	assign rr_we = (clearing_q && (clr_q < AW'(MAX_WIDTH))) || v_s2;
	assign rr_wa = clearing_q ? clr_q[CW-1:0] : col_s2;
	assign rr_wd = clearing_q ? '0 : sum;

	// Frame store, one read and one write a cycle.
	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_wa] <= fr_wd;
		end
		fr_rd_s1 <= fr_mem[q_addr];
	end

	// Integral row above.
	always_ff @(posedge clk) begin
		if (rr_we) begin
			rr_mem[rr_wa] <= rr_wd;
		end
		rr_rd_s2 <= rr_mem[col_s1];
	end

	// Control: clearing sweep, stage valids, credit count and row sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			outst_q    <= '0;
			rowsum_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(FD - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (q_pop && !out_taken) begin
				outst_q <= outst_q + OW'(1);
			end else if (out_taken && !q_pop) begin
				outst_q <= outst_q - OW'(1);
			end
			if (v_s2) begin
				rowsum_q <= line_end_s2 ? '0 : rs_next;
			end
			v_s1 <= q_pop;
			v_s2 <= v_s1;
		end
	end

	// Pipeline payload and bypass flags.
	always_ff @(posedge clk) begin
		tag_s1         <= q_tag;
		addr_s1        <= q_addr;
		col_s1         <= q_col;
		fr_fwd_s1      <= v_s1 && (addr_s1 == q_addr);
		fr_fwd_word_s1 <= wr_word;
		motion_s2      <= motion;
		row_zero_s2    <= tag_s1.row_zero;
		line_end_s2    <= tag_s1.line_end;
		frame_end_s2   <= tag_s1.frame_end;
		col_s2         <= col_s1;
		rr_fwd_s2      <= v_s2 && (col_s2 == col_s1);
		rr_fwd_sum_s2  <= sum;
	end

	assign res_valid = v_s2;

	always_comb begin
		res.frame_end    = frame_end_s2;
		res.integral_sum = sum;
		res.motion       = motion_s2;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/frame_difference_integral_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents
// s_axis    in         tdata: blue[7:0], green[15:8], red[23:16]
// m_axis    out        tdata: motion[7:0], integral_sum[34:8], zero[39:35]; tlast: frame_end
// cfg       in         cfg_we, cfg_index (0 width, 1 height, 2 three-frame mode), cfg_data
//
// One pixel per clock sustained when neither side stalls; the frame store takes one read
// and one write a cycle. A pixel passes the product stage, the queue, stages 1 and 2 and
// the output buffer. After reset all MAX_WIDTH*MAX_HEIGHT frame store words (307200 at the
// defaults) are swept to zero with s_axis_tready low; configuration writes are taken.
// A queue between the front and the back, and an output buffer, let either side stall.
module frame_difference_integral_unit #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [fdi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // blue, green, red
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic      [fdi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // motion, integral_sum, zero pad
	output logic                                     m_axis_tlast,
	input  wire logic                                cfg_we,
	input  wire logic [fdi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [fdi_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import fdi_pkg::*;

	localparam int AW        = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int TAG_W     = $bits(fdi_tag_t);
	localparam int QW        = CW + AW + TAG_W;
	localparam int RES_W     = $bits(fdi_result_t);
	localparam int Q_DEPTH   = 4;
	localparam int OUT_DEPTH = 8;

	logic          clear_busy;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	fdi_tag_t      f_tag;
	logic [AW-1:0] f_addr;
	logic [CW-1:0] f_col;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;
	fdi_tag_t      b_tag;
	logic [AW-1:0] b_addr;
	logic [CW-1:0] b_col;

	logic        res_valid;
	fdi_result_t res;
	fdi_result_t out_res;
	logic        out_full;
	logic        out_empty;
	logic        out_taken;

	fdi_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_tag      (f_tag),
		.q_addr     (f_addr),
		.q_col      (f_col)
	);

	// Queue of classified pixels between front and back.
	assign q_wdata = {f_col, f_addr, f_tag};

	fdi_fifo #(
		.WIDTH (QW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign b_tag  = fdi_tag_t'(q_rdata[TAG_W-1:0]);
	assign b_addr = q_rdata[TAG_W +: AW];
	assign b_col  = q_rdata[TAG_W+AW +: CW];

	fdi_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (!q_empty),
		.q_tag      (b_tag),
		.q_addr     (b_addr),
		.q_col      (b_col),
		.q_pop      (q_pop),
		.out_taken  (out_taken),
		.res_valid  (res_valid),
		.res        (res),
		.clear_busy (clear_busy)
	);

	// Output buffer; the back only issues work it has room for here.
	fdi_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.pop    (out_taken),
		.rdata  (out_res),
		.full   (out_full),
		.empty  (out_empty)
	);

	assign m_axis_tvalid = !out_empty;
	assign out_taken     = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = {(OUT_TDATA_W - INT_W - PIX_W)'(0), out_res.integral_sum,
		out_res.motion};
	assign m_axis_tlast  = out_res.frame_end;

`ifndef ASSERT_OFF
	// A result never arrives at a full output buffer.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("result pushed into full output buffer");

	// Nothing is in flight while the frame stores are being cleared.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> (q_empty && out_empty && !res_valid))
		else $error("item in flight during clearing sweep");

	// The back pops only from a queue that holds an entry.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
